/* design/pwmr_pkg.sv */
// -----------------------------------------------------------------------------
// pwmr_pkg
// Shared types and constants for the PWM generator with triangle ramp.
// -----------------------------------------------------------------------------
package pwmr_pkg;

   localparam int SAMPLE_BITS = 10;
   localparam int POT_W       = 10;
   localparam int DIV_W       = 16;
   localparam int TICK_W      = 8;
   localparam int CYC_W       = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 16;

   // divide by ten: (x * 0xCCCD) >> 19, exact for any 16-bit x
   localparam logic [DIV_W-1:0] DIV10_MULT  = 16'hCCCD;
   localparam int               DIV10_SHIFT = 19;
   localparam int               QUOT_W      = 2 * DIV_W - DIV10_SHIFT;

   localparam logic [DIV_W-1:0] SAMPLE_MASK =
      DIV_W'((32'd1 << SAMPLE_BITS) - 32'd1);

   localparam logic [TICK_W-1:0] PERIOD_RESET = 8'd100;
   localparam logic [TICK_W-1:0] LIMIT_RESET  = 8'd100;
   localparam logic [TICK_W-1:0] STEP_RESET   = 8'd2;
   localparam logic [CYC_W-1:0]  CYCLES_RESET = 4'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PERIOD_TICKS = 2'd0,
      REG_ON_LIMIT     = 2'd1,
      REG_RAMP_STEP    = 2'd2,
      REG_CYCLE_LIMIT  = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic [TICK_W-1:0] period_ticks;
      logic [TICK_W-1:0] on_limit;
      logic [TICK_W-1:0] ramp_step;
      logic [CYC_W-1:0]  cycle_limit;
   } cfg_type;

   typedef struct packed {
      logic              ramp_done;
      logic [TICK_W-1:0] on_time;
      logic              pwm_level;
   } result_type;

endpackage

/* design/pwmr_csr.sv */
// -----------------------------------------------------------------------------
// pwmr_csr
// Configuration register bank, write-only.
// -----------------------------------------------------------------------------
module pwmr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [pwmr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pwmr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output pwmr_pkg::cfg_type                   cfg
);

   pwmr_pkg::cfg_type cfg_ff;
   pwmr_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (pwmr_pkg::csr_reg_type'(csr_index))
            pwmr_pkg::REG_PERIOD_TICKS: cfg_in.period_ticks = csr_wdata;
            pwmr_pkg::REG_ON_LIMIT:     cfg_in.on_limit     = csr_wdata;
            pwmr_pkg::REG_RAMP_STEP:    cfg_in.ramp_step    = csr_wdata;
            pwmr_pkg::REG_CYCLE_LIMIT:
               cfg_in.cycle_limit = csr_wdata[pwmr_pkg::CYC_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_ticks <= pwmr_pkg::PERIOD_RESET;
         cfg_ff.on_limit     <= pwmr_pkg::LIMIT_RESET;
         cfg_ff.ramp_step    <= pwmr_pkg::STEP_RESET;
         cfg_ff.cycle_limit  <= pwmr_pkg::CYCLES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/pwmr_core.sv */
// -----------------------------------------------------------------------------
// pwmr_core
// Per-tick PWM state and on-time update, one tick per advance.
// -----------------------------------------------------------------------------
module pwmr_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             auto_mode,
   input  logic [pwmr_pkg::POT_W-1:0]       pot_sample,
   input  pwmr_pkg::cfg_type                cfg,
   output pwmr_pkg::result_type             result
);

   localparam int TW = pwmr_pkg::TICK_W;
   localparam int CW = pwmr_pkg::CYC_W;
   localparam int DW = pwmr_pkg::DIV_W;
   localparam int QW = pwmr_pkg::QUOT_W;

   logic [TW-1:0] phase_ff, phase_in;
   logic [TW-1:0] on_ff, on_in;
   logic          down_ff, down_in;
   logic [CW-1:0] cyc_ff, cyc_in;
   logic          armed_ff, armed_in;

   logic [DW-1:0]   sample;
   logic [2*DW-1:0] prod;
   logic [QW-1:0]   quot;
   logic [TW-1:0]   period;
   logic [TW:0]     ramp_sum;
   logic [TW:0]     phase_inc;
   logic            held;

   assign sample = {{(DW-pwmr_pkg::POT_W){1'b0}}, pot_sample} & pwmr_pkg::SAMPLE_MASK;
   assign prod   = sample * pwmr_pkg::DIV10_MULT;
   assign quot   = prod[2*DW-1:pwmr_pkg::DIV10_SHIFT];
   assign period = (cfg.period_ticks == '0) ? TW'(1) : cfg.period_ticks;

   always_comb begin
      on_in    = on_ff;
      down_in  = down_ff;
      cyc_in   = cyc_ff;
      armed_in = armed_ff;
      held     = 1'b0;
      ramp_sum = '0;
      if (phase_ff == '0) begin
         if (!auto_mode) begin
            armed_in = 1'b0;
            if (quot > QW'(cfg.on_limit)) on_in = cfg.on_limit;
            else                          on_in = quot[TW-1:0];
         end else begin
            if (!armed_ff) begin
               armed_in = 1'b1;
               cyc_in   = '0;
               on_in    = '0;
            end
            if (cyc_in == cfg.cycle_limit) begin
               held = 1'b1;
            end else if (down_ff) begin
               if (on_in < cfg.ramp_step) begin
                  on_in   = '0;
                  down_in = 1'b0;
                  cyc_in  = cyc_in + CW'(1);
               end else begin
                  on_in = on_in - cfg.ramp_step;
               end
            end else begin
               ramp_sum = {1'b0, on_in} + {1'b0, cfg.ramp_step};
               if (ramp_sum > {1'b0, cfg.on_limit}) begin
                  on_in   = cfg.on_limit;
                  down_in = 1'b1;
               end else begin
                  on_in = ramp_sum[TW-1:0];
               end
            end
         end
      end

      phase_inc = {1'b0, phase_ff} + (TW+1)'(1);
      if (held)                           phase_in = '0;
      else if (phase_inc >= {1'b0, period}) phase_in = '0;
      else                                phase_in = phase_inc[TW-1:0];

      result.pwm_level = !held && (phase_ff < on_in);
      result.on_time   = on_in;
      result.ramp_done = held;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         on_ff    <= '0;
         down_ff  <= 1'b0;
         cyc_ff   <= '0;
         armed_ff <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         on_ff    <= on_in;
         down_ff  <= down_in;
         cyc_ff   <= cyc_in;
         armed_ff <= armed_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (phase_ff == '0) && (on_ff == '0) && !armed_ff)
      else $error("state not cleared by reset");

   a_held_restarts: assert property (@(posedge clock) disable iff (reset)
      advance && held && armed_ff |=> (phase_ff == '0) && (on_ff == $past(on_ff)))
      else $error("held tick moved phase or on-time");

   a_top_reversal: assert property (@(posedge clock) disable iff (reset)
      advance && !down_ff && down_in |=> on_ff == $past(cfg.on_limit))
      else $error("top reversal did not land on limit");

   a_bottom_reversal: assert property (@(posedge clock) disable iff (reset)
      advance && down_ff && !down_in |=> (on_ff == '0) && armed_ff)
      else $error("bottom reversal did not land on zero");

endmodule

/* design/pwm_generator_with_ramp_unit.sv */
// -----------------------------------------------------------------------------
// pwm_generator_with_ramp_unit
// PWM generator whose on-time follows a pot sample or a triangle ramp.
// -----------------------------------------------------------------------------
// Usage:
//   req_* carries one beat per millisecond tick: mode switch and pot sample.
//   rsp_* returns one beat per tick: output level, current on-time and a
//   flag set while the finished auto ramp holds the output off.
//   csr_* writes the period, on-time limit, ramp step and cycle count;
//   write only while no tick is in flight.
// Path: a tick enters the input register, is computed combinationally in the
//   core, and its result beat is registered in the output register.
// Throughput: one tick per cycle while rsp_tready stays high; the period, ramp
//   and cycle state are updated by combinational logic after the input register.
// Reset: registers return to their defaults, phase and on-time go to zero,
//   ramp direction up, auto mode disarmed; no beat is held.
// Stall: with rsp_tready low the result register holds its beat, one more
//   tick waits in the input register, then req_tready drops.
// -----------------------------------------------------------------------------
module pwm_generator_with_ramp_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [0] auto_mode, [10:1] pot_sample, [15:11] zero
   input  logic [pwmr_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] pwm_level, [8:1] on_time, [9] ramp_done, [15:10] zero
   output logic [pwmr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_we,
   input  logic [pwmr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pwmr_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int RW = $bits(pwmr_pkg::result_type);

   pwmr_pkg::cfg_type    cfg;
   pwmr_pkg::result_type result;

   logic                          in_valid_ff, in_valid_in;
   logic                          in_auto_ff;
   logic [pwmr_pkg::POT_W-1:0]    in_pot_ff;
   logic                          out_valid_ff, out_valid_in;
   pwmr_pkg::result_type          out_data_ff;
   logic                          advance;

   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   pwmr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pwmr_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .auto_mode  (in_auto_ff),
      .pot_sample (in_pot_ff),
      .cfg        (cfg),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_auto_ff <= req_tdata[0];
         in_pot_ff  <= req_tdata[pwmr_pkg::POT_W:1];
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(pwmr_pkg::RSP_DATA_W-RW){1'b0}}, out_data_ff};

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PWM generator with triangle ramp. A short table
// of directed ticks and register writes comes first, then phases of random
// ticks, each under a fresh register setting. Every tick is predicted here and
// the result beats are checked field by field in arrival order. The sender
// works in bursts and the receiver stalls on its own pattern, with one long
// hold-off that backs the block up into its input.
// -----------------------------------------------------------------------------
module testbench;

   localparam int CLK_HALF      = 6;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RAND_PHASES   = 16;
   localparam int PHASE_TICKS   = 100;
   localparam int HOLD_PHASE    = 3;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int POT_DIVISOR   = 10;

   typedef struct packed {
      logic                            is_csr;
      pwmr_pkg::csr_reg_type           idx;
      logic [pwmr_pkg::TICK_W-1:0]     value;
      logic                            mode;
      logic [pwmr_pkg::POT_W-1:0]      pot;
      logic                            has_want;
      pwmr_pkg::result_type            want;
   } stim_row_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   // [0] auto_mode, [10:1] pot_sample, [15:11] zero
   logic [pwmr_pkg::REQ_DATA_W-1:0]   req_tdata = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   // [0] pwm_level, [8:1] on_time, [9] ramp_done, [15:10] zero
   logic [pwmr_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                              csr_we = 1'b0;
   logic [pwmr_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [pwmr_pkg::CSR_DATA_W-1:0]   csr_wdata = '0;

   // predictor state and register shadow
   pwmr_pkg::cfg_type                 shadow_cfg;
   logic [pwmr_pkg::TICK_W-1:0]       ph_cnt;
   logic [pwmr_pkg::TICK_W-1:0]       on_cur;
   logic                              ramp_dn;
   logic [pwmr_pkg::CYC_W-1:0]        cyc_cnt;
   logic                              armed;

   pwmr_pkg::result_type pwm_due_q[$];
   int         err_count   = 0;
   int         beats_seen  = 0;
   int         ticks_sent  = 0;
   int         settings    = 0;
   int         held_beats  = 0;
   int         cycle_count = 0;
   int         burst_left  = 0;
   bit         long_hold_req = 1'b0;

   pwm_generator_with_ramp_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d beats still due", cycle_count, pwm_due_q.size());
      $display("Some tests failed");
      $finish;
   end

   function automatic void ramp_advance();
      logic [pwmr_pkg::TICK_W:0] nxt;
      if (ramp_dn) begin
         if (on_cur < shadow_cfg.ramp_step) begin
            on_cur  = '0;
            ramp_dn = 1'b0;
            cyc_cnt = cyc_cnt + 1'b1;
         end else begin
            on_cur = on_cur - shadow_cfg.ramp_step;
         end
      end else begin
         nxt = {1'b0, on_cur} + {1'b0, shadow_cfg.ramp_step};
         if (nxt > {1'b0, shadow_cfg.on_limit}) begin
            on_cur  = shadow_cfg.on_limit;
            ramp_dn = 1'b1;
         end else begin
            on_cur = nxt[pwmr_pkg::TICK_W-1:0];
         end
      end
   endfunction

   function automatic pwmr_pkg::result_type next_pwm_beat(logic mode,
                                                          logic [pwmr_pkg::POT_W-1:0] pot);
      pwmr_pkg::result_type          r;
      int                            period;
      int                            quot;
      int                            nph;
      logic [pwmr_pkg::POT_W-1:0]    sample;
      bit                            held;
      held   = 1'b0;
      sample = pot & pwmr_pkg::SAMPLE_MASK[pwmr_pkg::POT_W-1:0];
      period = (shadow_cfg.period_ticks == '0) ? 1 : int'(shadow_cfg.period_ticks);
      if (ph_cnt == '0) begin
         if (!mode) begin
            quot   = int'(sample) / POT_DIVISOR;
            armed  = 1'b0;
            on_cur = (quot > int'(shadow_cfg.on_limit)) ? shadow_cfg.on_limit
                                                        : pwmr_pkg::TICK_W'(quot);
         end else begin
            if (!armed) begin
               armed   = 1'b1;
               cyc_cnt = '0;
               on_cur  = '0;
            end
            if (cyc_cnt == shadow_cfg.cycle_limit) held = 1'b1;
            else ramp_advance();
         end
      end
      r.on_time = on_cur;
      if (held) begin
         r.pwm_level = 1'b0;
         r.ramp_done = 1'b1;
         ph_cnt      = '0;
      end else begin
         r.pwm_level = (ph_cnt < on_cur);
         r.ramp_done = 1'b0;
         nph         = int'(ph_cnt) + 1;
         ph_cnt      = (nph >= period) ? '0 : pwmr_pkg::TICK_W'(nph);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH beat %0d: %s got %0d want %0d", beats_seen, what, got, want);
      err_count++;
   endtask

   always @(posedge clock) begin
      pwmr_pkg::result_type got;
      pwmr_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = pwmr_pkg::result_type'(rsp_tdata[$bits(pwmr_pkg::result_type)-1:0]);
         if (pwm_due_q.size() == 0) begin
            report_mismatch("beat with nothing due, tdata", int'(rsp_tdata), 0);
         end else begin
            want = pwm_due_q.pop_front();
            if (got.pwm_level != want.pwm_level)
               report_mismatch("pwm_level", got.pwm_level, want.pwm_level);
            if (got.on_time != want.on_time)
               report_mismatch("on_time", got.on_time, want.on_time);
            if (got.ramp_done != want.ramp_done)
               report_mismatch("ramp_done", got.ramp_done, want.ramp_done);
            if (want.ramp_done) held_beats++;
         end
         beats_seen++;
      end
   end

   // receiver: segments of always-ready, random, periodic and short stalls
   initial begin
      int seg_kind;
      int seg_len;
      int k;
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            for (k = 0; k < HOLD_CYCLES; k++) @(posedge clock);
         end
         seg_kind = $urandom_range(0, 3);
         seg_len  = $urandom_range(1, 40);
         for (k = 0; k < seg_len; k++) begin
            case (seg_kind)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (k % 3 != 0);
               default: rsp_tready <= (k >= 8);
            endcase
            @(posedge clock);
         end
      end
   end

   task automatic write_csr(pwmr_pkg::csr_reg_type idx,
                            logic [pwmr_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         pwmr_pkg::REG_PERIOD_TICKS: shadow_cfg.period_ticks = value;
         pwmr_pkg::REG_ON_LIMIT:     shadow_cfg.on_limit     = value;
         pwmr_pkg::REG_RAMP_STEP:    shadow_cfg.ramp_step    = value;
         pwmr_pkg::REG_CYCLE_LIMIT:
            shadow_cfg.cycle_limit = value[pwmr_pkg::CYC_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pwm_due_q.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_tick(logic mode, logic [pwmr_pkg::POT_W-1:0] pot, logic has_want,
                            pwmr_pkg::result_type want);
      pwmr_pkg::result_type pred;
      req_tdata  <= {{(pwmr_pkg::REQ_DATA_W-pwmr_pkg::POT_W-1){1'b0}}, pot, mode};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = next_pwm_beat(mode, pot);
      pwm_due_q.push_back(has_want ? want : pred);
      ticks_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(0, 15);
      end
   endtask

   function automatic stim_row_type tick_row(logic mode, logic [pwmr_pkg::POT_W-1:0] pot,
                                             logic has_want, pwmr_pkg::result_type want);
      stim_row_type r;
      r          = '0;
      r.mode     = mode;
      r.pot      = pot;
      r.has_want = has_want;
      r.want     = want;
      return r;
   endfunction

   function automatic stim_row_type csr_row(pwmr_pkg::csr_reg_type idx,
                                            logic [pwmr_pkg::TICK_W-1:0] value);
      stim_row_type r;
      r        = '0;
      r.is_csr = 1'b1;
      r.idx    = idx;
      r.value  = value;
      return r;
   endfunction

   function automatic pwmr_pkg::result_type beat(logic done,
                                                 logic [pwmr_pkg::TICK_W-1:0] on_t,
                                                 logic lvl);
      pwmr_pkg::result_type r;
      r.ramp_done = done;
      r.on_time   = on_t;
      r.pwm_level = lvl;
      return r;
   endfunction

   initial begin
      stim_row_type         dir_rows[$];
      pwmr_pkg::result_type none;
      logic                 mode;
      int                   n_dir;
      int                   p;
      int                   t;
      none         = '0;
      shadow_cfg   = '{pwmr_pkg::PERIOD_RESET, pwmr_pkg::LIMIT_RESET,
                       pwmr_pkg::STEP_RESET, pwmr_pkg::CYCLES_RESET};
      ph_cnt       = '0;
      on_cur       = '0;
      ramp_dn      = 1'b0;
      cyc_cnt      = '0;
      armed        = 1'b0;

      dir_rows = '{
         tick_row(1'b0, 10'd1023, 1'b1, beat(1'b0, 8'd100, 1'b1)),
         tick_row(1'b0, 10'd5,    1'b1, beat(1'b0, 8'd100, 1'b1)),
         csr_row(pwmr_pkg::REG_PERIOD_TICKS, 8'd0),
         tick_row(1'b0, 10'd0,    1'b0, none),
         tick_row(1'b0, 10'd0,    1'b1, beat(1'b0, 8'd0, 1'b0)),
         tick_row(1'b0, 10'd999,  1'b1, beat(1'b0, 8'd99, 1'b1)),
         csr_row(pwmr_pkg::REG_ON_LIMIT, 8'd255),
         csr_row(pwmr_pkg::REG_RAMP_STEP, 8'd255),
         csr_row(pwmr_pkg::REG_CYCLE_LIMIT, 8'd1),
         tick_row(1'b0, 10'd1023, 1'b1, beat(1'b0, 8'd102, 1'b1)),
         tick_row(1'b1, 10'h2AA,  1'b0, none),
         tick_row(1'b1, 10'h155,  1'b0, none),
         tick_row(1'b1, 10'd0,    1'b0, none),
         tick_row(1'b1, 10'd1023, 1'b0, none),
         tick_row(1'b1, 10'd7,    1'b1, beat(1'b1, 8'd0, 1'b0)),
         tick_row(1'b1, 10'd8,    1'b1, beat(1'b1, 8'd0, 1'b0)),
         tick_row(1'b0, 10'd512,  1'b0, none),
         csr_row(pwmr_pkg::REG_CYCLE_LIMIT, 8'd15),
         tick_row(1'b1, 10'd0,    1'b0, none),
         tick_row(1'b1, 10'd0,    1'b0, none),
         tick_row(1'b0, 10'd300,  1'b0, none),
         tick_row(1'b1, 10'd0,    1'b0, none),
         csr_row(pwmr_pkg::REG_PERIOD_TICKS, 8'd3),
         tick_row(1'b0, 10'd1000, 1'b1, beat(1'b0, 8'd100, 1'b1)),
         tick_row(1'b0, 10'd1000, 1'b1, beat(1'b0, 8'd100, 1'b1)),
         tick_row(1'b0, 10'd1000, 1'b1, beat(1'b0, 8'd100, 1'b1)),
         csr_row(pwmr_pkg::REG_CYCLE_LIMIT, 8'd0),
         tick_row(1'b1, 10'd1023, 1'b1, beat(1'b1, 8'd0, 1'b0))
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_csr) begin
            drain();
            write_csr(dir_rows[i].idx, dir_rows[i].value);
            settings++;
         end else begin
            send_tick(dir_rows[i].mode, dir_rows[i].pot, dir_rows[i].has_want,
                      dir_rows[i].want);
         end
      end
      n_dir = ticks_sent;

      mode = 1'b1;
      for (p = 0; p < RAND_PHASES; p++) begin
         drain();
         case (p)
            0: begin
               write_csr(pwmr_pkg::REG_PERIOD_TICKS, 8'd1);
               write_csr(pwmr_pkg::REG_ON_LIMIT, 8'd0);
               write_csr(pwmr_pkg::REG_RAMP_STEP, 8'd1);
               write_csr(pwmr_pkg::REG_CYCLE_LIMIT, 8'd0);
            end
            1: begin
               write_csr(pwmr_pkg::REG_PERIOD_TICKS, 8'd255);
               write_csr(pwmr_pkg::REG_ON_LIMIT, 8'd255);
               write_csr(pwmr_pkg::REG_RAMP_STEP, 8'd255);
               write_csr(pwmr_pkg::REG_CYCLE_LIMIT, 8'd15);
            end
            2: begin
               write_csr(pwmr_pkg::REG_PERIOD_TICKS, pwmr_pkg::PERIOD_RESET);
               write_csr(pwmr_pkg::REG_ON_LIMIT, pwmr_pkg::LIMIT_RESET);
               write_csr(pwmr_pkg::REG_RAMP_STEP, pwmr_pkg::STEP_RESET);
               write_csr(pwmr_pkg::REG_CYCLE_LIMIT, 8'(pwmr_pkg::CYCLES_RESET));
            end
            default: begin
               case ($urandom_range(0, 5))
                  0:       write_csr(pwmr_pkg::REG_PERIOD_TICKS, 8'd0);
                  1:       write_csr(pwmr_pkg::REG_PERIOD_TICKS, 8'd255);
                  2:       write_csr(pwmr_pkg::REG_PERIOD_TICKS, 8'($urandom_range(2, 20)));
                  default: write_csr(pwmr_pkg::REG_PERIOD_TICKS, 8'($urandom_range(1, 6)));
               endcase
               case ($urandom_range(0, 4))
                  0:       write_csr(pwmr_pkg::REG_ON_LIMIT, 8'd0);
                  1:       write_csr(pwmr_pkg::REG_ON_LIMIT, 8'd255);
                  2:       write_csr(pwmr_pkg::REG_ON_LIMIT, 8'($urandom_range(0, 100)));
                  default: write_csr(pwmr_pkg::REG_ON_LIMIT, 8'($urandom_range(1, 30)));
               endcase
               case ($urandom_range(0, 4))
                  0:       write_csr(pwmr_pkg::REG_RAMP_STEP, 8'd1);
                  1:       write_csr(pwmr_pkg::REG_RAMP_STEP, 8'd255);
                  2:       write_csr(pwmr_pkg::REG_RAMP_STEP, 8'($urandom_range(1, 40)));
                  default: write_csr(pwmr_pkg::REG_RAMP_STEP, 8'($urandom_range(1, 8)));
               endcase
               case ($urandom_range(0, 4))
                  0:       write_csr(pwmr_pkg::REG_CYCLE_LIMIT, 8'd0);
                  1:       write_csr(pwmr_pkg::REG_CYCLE_LIMIT, 8'd15);
                  default: write_csr(pwmr_pkg::REG_CYCLE_LIMIT, 8'($urandom_range(1, 4)));
               endcase
            end
         endcase
         settings++;
         if (p == HOLD_PHASE) begin
            long_hold_req = 1'b1;
            burst_left    = PHASE_TICKS;
         end
         for (t = 0; t < PHASE_TICKS; t++) begin
            // mostly auto runs, with occasional manual stretches that re-arm the ramp
            if ($urandom_range(0, 11) == 0) mode = ~mode;
            if (!mode && $urandom_range(0, 2) == 0) mode = 1'b1;
            case ($urandom_range(0, 7))
               0:       send_tick(mode, 10'd0, 1'b0, none);
               1:       send_tick(mode, 10'd1023, 1'b0, none);
               default: send_tick(mode, 10'($urandom_range(0, 1023)), 1'b0, none);
            endcase
         end
      end
      drain();

      if (pwm_due_q.size() > 0)
         report_mismatch("beats never returned", 0, pwm_due_q.size());
      $display("Ran %0d directed and %0d random ticks under %0d register settings",
               n_dir, ticks_sent - n_dir, settings);
      $display("Checked %0d result beats, %0d of them with the ramp held off",
               beats_seen, held_beats);
      if (err_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", err_count);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
